@@ rtl/npe_pkg.sv @@
// Shared types, widths and helpers for the nearest polygon edge search block.
// No dependencies; imported by every module of the block.
package npe_pkg;

  localparam int CoordW = 14;
  localparam int DiffW  = 15;
  localparam int OpW    = 31;
  localparam int ProdW  = 62;
  localparam int AccW   = 89;
  localparam int NumW   = 58;
  localparam int DenW   = 29;
  localparam int HalfW  = 29;
  localparam int CabsW  = 30;
  localparam int CmpW   = 87;
  localparam int IdxW   = 10;

  typedef logic signed [CoordW-1:0] coord_t;

  // One queued request from the front part: the edge that closes at this vertex,
  // and the closing edge back to the first vertex when the item is the last one.
  typedef struct packed {
    coord_t          qx;
    coord_t          qy;
    coord_t          px;
    coord_t          py;
    coord_t          cx;
    coord_t          cy;
    coord_t          lx;
    coord_t          ly;
    coord_t          sx;
    coord_t          sy;
    logic [IdxW-1:0] index;
    logic            restart;
    logic            do_edge;
    logic            do_close;
  } task_t;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] index;
  } result_t;

  typedef enum logic [15:0] {
    ST_IDLE = 16'b0000_0000_0000_0001,
    ST_DV0  = 16'b0000_0000_0000_0010,
    ST_DV1  = 16'b0000_0000_0000_0100,
    ST_DW0  = 16'b0000_0000_0000_1000,
    ST_DW1  = 16'b0000_0000_0001_0000,
    ST_CR0  = 16'b0000_0000_0010_0000,
    ST_CR1  = 16'b0000_0000_0100_0000,
    ST_N0   = 16'b0000_0000_1000_0000,
    ST_N1   = 16'b0000_0001_0000_0000,
    ST_D0   = 16'b0000_0010_0000_0000,
    ST_D1   = 16'b0000_0100_0000_0000,
    ST_X0   = 16'b0000_1000_0000_0000,
    ST_X1   = 16'b0001_0000_0000_0000,
    ST_Y0   = 16'b0010_0000_0000_0000,
    ST_Y1   = 16'b0100_0000_0000_0000,
    ST_OUT  = 16'b1000_0000_0000_0000
  } back_state_e;

  function automatic logic signed [OpW-1:0] sext_diff(input logic signed [DiffW-1:0] v);
    return {{(OpW-DiffW){v[DiffW-1]}}, v};
  endfunction

  function automatic logic signed [DiffW-1:0] diff(input coord_t a, input coord_t b);
    return {a[CoordW-1], a} - {b[CoordW-1], b};
  endfunction

endpackage

@@ rtl/npe_front.sv @@
// Front part: accepts vertex requests, tracks the open polygon and builds edge tasks.
// Depends on npe_pkg.
module npe_front import npe_pkg::*; #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   accept_i,
  input  coord_t query_x_i,
  input  coord_t query_y_i,
  input  coord_t vertex_x_i,
  input  coord_t vertex_y_i,
  input  logic   first_vertex_i,
  input  logic   last_vertex_i,
  output task_t  task_o
);

  localparam int CntW = $clog2(MAX_VERTICES + 1);

  logic [CntW-1:0] count_q, count_d;
  coord_t start_x_q, start_y_q, prior_x_q, prior_y_q;
  logic start, can_add;

  assign start   = first_vertex_i || (count_q == '0);
  assign can_add = count_q < CntW'(MAX_VERTICES);

  always_comb begin
    task_o.qx       = query_x_i;
    task_o.qy       = query_y_i;
    task_o.px       = prior_x_q;
    task_o.py       = prior_y_q;
    task_o.cx       = vertex_x_i;
    task_o.cy       = vertex_y_i;
    task_o.lx       = (start || can_add) ? vertex_x_i : prior_x_q;
    task_o.ly       = (start || can_add) ? vertex_y_i : prior_y_q;
    task_o.sx       = start ? vertex_x_i : start_x_q;
    task_o.sy       = start ? vertex_y_i : start_y_q;
    task_o.index    = IdxW'(count_q);
    task_o.restart  = start;
    task_o.do_edge  = !start && can_add;
    task_o.do_close = last_vertex_i;
  end

  always_comb begin
    count_d = count_q;
    if (accept_i) begin
      if (start) begin
        count_d = CntW'(1);
      end else if (can_add) begin
        count_d = count_q + CntW'(1);
      end
      if (last_vertex_i) begin
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      start_x_q <= '0;
      start_y_q <= '0;
      prior_x_q <= '0;
      prior_y_q <= '0;
    end else begin
      count_q <= count_d;
      if (accept_i && (start || can_add)) begin
        prior_x_q <= vertex_x_i;
        prior_y_q <= vertex_y_i;
      end
      if (accept_i && start) begin
        start_x_q <= vertex_x_i;
        start_y_q <= vertex_y_i;
      end
    end
  end

endmodule

@@ rtl/npe_queue.sv @@
// Two-entry request queue between the front and back parts.
// Depends on npe_pkg for task_t.
module npe_queue import npe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  task_t data_i,
  input  logic  pop_i,
  output task_t data_o,
  output logic  full_o,
  output logic  empty_o
);

  task_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/npe_back.sv @@
// Back part: sequences one shared 31x31 multiply-accumulate through the edge distance
// and the cross-multiplied fraction compare; keeps the running best. Depends on npe_pkg.
module npe_back import npe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  task_t   q_data_i,
  output logic    q_pop_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  back_state_e state_q, state_d;
  task_t t_q;
  logic  ph_q;
  logic  have_q;
  logic  dvneg_q, dwpos_q;
  logic [CabsW-1:0] cabs_q;
  logic [NumW-1:0]  num_q, best_num_q;
  logic [DenW-1:0]  den_q, best_den_q;
  logic [IdxW-1:0]  best_idx_q, res_idx_q;
  logic [CmpW-1:0]  x_q;
  logic signed [AccW-1:0] acc_q, r;

  coord_t gpx, gpy, gcx, gcy;
  logic signed [DiffW-1:0] ax, ay, vx, vy, wx, wy, nay;
  logic signed [OpW-1:0] op_a, op_b;
  logic signed [ProdW-1:0] prod;
  logic keep, shift;
  logic zero_len, perp, less, take;
  logic [NumW-1:0] na, nb;
  logic [DenW-1:0] da, db;

  // Edge under evaluation: the closing edge runs from the latest vertex to the first
  assign gpx = ph_q ? t_q.lx : t_q.px;
  assign gpy = ph_q ? t_q.ly : t_q.py;
  assign gcx = ph_q ? t_q.sx : t_q.cx;
  assign gcy = ph_q ? t_q.sy : t_q.cy;
  assign ax  = diff(gcx, gpx);
  assign ay  = diff(gcy, gpy);
  assign vx  = diff(t_q.qx, gpx);
  assign vy  = diff(t_q.qy, gpy);
  assign wx  = diff(t_q.qx, gcx);
  assign wy  = diff(t_q.qy, gcy);
  assign nay = -ay;

  assign zero_len = (ax == '0) && (ay == '0);
  assign perp     = !zero_len && !dvneg_q && !dwpos_q;

  // new/best for an inner edge, best/new for the closing edge; strict less in both
  assign na = ph_q ? best_num_q : num_q;
  assign da = ph_q ? best_den_q : den_q;
  assign nb = ph_q ? num_q : best_num_q;
  assign db = ph_q ? den_q : best_den_q;

  always_comb begin
    op_a  = '0;
    op_b  = '0;
    keep  = 1'b0;
    shift = 1'b0;
    unique case (state_q)
      ST_DV0: begin op_a = sext_diff(vx); op_b = sext_diff(ax); end
      ST_DV1: begin op_a = sext_diff(vy); op_b = sext_diff(ay); keep = 1'b1; end
      ST_DW0: begin op_a = sext_diff(wx); op_b = sext_diff(ax); end
      ST_DW1: begin op_a = sext_diff(wy); op_b = sext_diff(ay); keep = 1'b1; end
      ST_CR0: begin op_a = sext_diff(ax); op_b = sext_diff(vy); end
      ST_CR1: begin op_a = sext_diff(nay); op_b = sext_diff(vx); keep = 1'b1; end
      ST_N0: begin
        if (perp) begin
          op_a = {1'b0, cabs_q};
          op_b = {1'b0, cabs_q};
        end else if (zero_len || dvneg_q) begin
          op_a = sext_diff(vx);
          op_b = sext_diff(vx);
        end else begin
          op_a = sext_diff(wx);
          op_b = sext_diff(wx);
        end
      end
      ST_N1: begin
        keep = 1'b1;
        if (perp) begin
          op_a = '0;
          op_b = '0;
        end else if (zero_len || dvneg_q) begin
          op_a = sext_diff(vy);
          op_b = sext_diff(vy);
        end else begin
          op_a = sext_diff(wy);
          op_b = sext_diff(wy);
        end
      end
      ST_D0: begin
        op_a = perp ? sext_diff(ax) : OpW'(1);
        op_b = perp ? sext_diff(ax) : OpW'(1);
      end
      ST_D1: begin
        op_a = perp ? sext_diff(ay) : '0;
        op_b = perp ? sext_diff(ay) : '0;
        keep = 1'b1;
      end
      ST_X0: begin op_a = {2'b00, na[NumW-1:HalfW]}; op_b = {2'b00, db}; end
      ST_X1: begin op_a = {2'b00, na[HalfW-1:0]}; op_b = {2'b00, db}; keep = 1'b1; shift = 1'b1; end
      ST_Y0: begin op_a = {2'b00, nb[NumW-1:HalfW]}; op_b = {2'b00, da}; end
      ST_Y1: begin op_a = {2'b00, nb[HalfW-1:0]}; op_b = {2'b00, da}; keep = 1'b1; shift = 1'b1; end
      ST_IDLE, ST_OUT: begin end
      default: begin end
    endcase
  end

  assign prod = op_a * op_b;
  assign r    = (keep ? (shift ? (acc_q <<< HalfW) : acc_q) : '0) + AccW'(prod);
  assign less = x_q < r[CmpW-1:0];
  assign take = !have_q || less;

  assign q_pop_o     = (state_q == ST_IDLE) && !q_empty_i;
  assign res_o.valid = (state_q == ST_OUT) && res_ready_i;
  assign res_o.index = res_idx_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i && (q_data_i.do_edge || q_data_i.do_close)) begin
          state_d = ST_DV0;
        end
      end
      ST_DV0: state_d = ST_DV1;
      ST_DV1: state_d = ST_DW0;
      ST_DW0: state_d = ST_DW1;
      ST_DW1: state_d = ST_CR0;
      ST_CR0: state_d = ST_CR1;
      ST_CR1: state_d = ST_N0;
      ST_N0:  state_d = ST_N1;
      ST_N1:  state_d = ST_D0;
      ST_D0:  state_d = ST_D1;
      ST_D1:  state_d = ST_X0;
      ST_X0:  state_d = ST_X1;
      ST_X1:  state_d = ST_Y0;
      ST_Y0:  state_d = ST_Y1;
      ST_Y1: begin
        if (ph_q) begin
          state_d = ST_OUT;
        end else if (t_q.do_close) begin
          state_d = ST_DV0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= 1'b0;
      have_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        ph_q <= !q_data_i.do_edge;
        if (q_data_i.restart) begin
          have_q <= 1'b0;
        end
      end
      if (state_q == ST_Y1 && !ph_q) begin
        ph_q <= 1'b1;
        if (take) begin
          have_q <= 1'b1;
        end
      end
      if (res_o.valid) begin
        have_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= r;
    if (q_pop_o) begin
      t_q <= q_data_i;
    end
    if (state_q == ST_DV1) begin
      dvneg_q <= r[AccW-1];
    end
    if (state_q == ST_DW1) begin
      dwpos_q <= !r[AccW-1] && (r != '0);
    end
    if (state_q == ST_CR1) begin
      cabs_q <= r[AccW-1] ? CabsW'(-r) : r[CabsW-1:0];
    end
    if (state_q == ST_N1) begin
      num_q <= r[NumW-1:0];
    end
    if (state_q == ST_D1) begin
      den_q <= r[DenW-1:0];
    end
    if (state_q == ST_X1) begin
      x_q <= r[CmpW-1:0];
    end
    if (state_q == ST_Y1) begin
      if (!ph_q && take) begin
        best_num_q <= num_q;
        best_den_q <= den_q;
        best_idx_q <= t_q.index;
      end
      res_idx_q <= (have_q && less) ? best_idx_q : '0;
    end
  end

endmodule

@@ rtl/nearest_polygon_edge_search_top.sv @@
// Channel   | Direction | Handshake          | Payload
// vertex    | in        | push / full        | query_x_i query_y_i vertex_x_i vertex_y_i
//           |           |                    | first_vertex_i last_vertex_i
// result    | out       | pop / empty        | edge_index_o
//
// A vertex that closes an edge runs the back part through the DV, DW, CR, N, D, X and Y
// steps; an item marked last also runs them for the closing edge, then hands over the
// result in ST_OUT. The single multiply-accumulate unit is stepped once per cycle.
// The two-entry request queue lets the front keep accepting while the back works.
// rst_ni clears all control state asynchronously; no storage needs a clearing pass.
// Top level of the nearest polygon edge search; depends on npe_pkg, npe_front,
// npe_queue and npe_back.
module nearest_polygon_edge_search_top import npe_pkg::*; #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  coord_t          query_x_i,
  input  coord_t          query_y_i,
  input  coord_t          vertex_x_i,
  input  coord_t          vertex_y_i,
  input  logic            first_vertex_i,
  input  logic            last_vertex_i,
  output logic            empty,
  input  logic            pop,
  output logic [IdxW-1:0] edge_index_o
);

  logic    in_accept, q_full, q_empty, q_pop, res_ready;
  task_t   front_task, q_task;
  result_t res;
  logic    out_valid_q;
  logic [IdxW-1:0] edge_q;

  assign full      = q_full;
  assign in_accept = push && !q_full;

  npe_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk_i,
    .rst_ni,
    .accept_i       (in_accept),
    .query_x_i,
    .query_y_i,
    .vertex_x_i,
    .vertex_y_i,
    .first_vertex_i,
    .last_vertex_i,
    .task_o         (front_task)
  );

  npe_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (in_accept),
    .data_i  (front_task),
    .pop_i   (q_pop),
    .data_o  (q_task),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign res_ready = !out_valid_q || pop;

  npe_back u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i   (q_empty),
    .q_data_i    (q_task),
    .q_pop_o     (q_pop),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      edge_q <= res.index;
    end
  end

  assign empty        = !out_valid_q;
  assign edge_index_o = edge_q;

  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (!out_valid_q || pop))
    else $error("result written over an unread result");

  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty))
    else $error("request queue flags disagree");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("back part took a request from an empty queue");

  a_res_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |=> out_valid_q)
    else $error("result slot not filled after write");

endmodule
